[rtl/tdfa_pkg.sv]
`timescale 1ns / 1ps
// Shared types, sizes and command codes for the table driven DFA matcher.
// Used by every module in rtl/; depends on nothing else.
package tdfa_pkg;

  // Automaton sizing
  localparam int NUM_STATES    = 64;
  localparam int SYMBOL_BITS   = 8;
  localparam int NUM_SYMBOLS   = 1 << SYMBOL_BITS;
  localparam int STATE_IDX_W   = (NUM_STATES > 1) ? $clog2(NUM_STATES) : 1;
  localparam int TBL_ADDR_W    = STATE_IDX_W + SYMBOL_BITS;
  localparam int TBL_DEPTH     = NUM_STATES * NUM_SYMBOLS;

  // Field widths of the beats on the ports
  localparam int CMD_W   = 3;
  localparam int STATE_W = 6;
  localparam int SYM_W   = 8;

  // Result queue sizing
  localparam int OUT_DEPTH = 3;
  localparam int OUT_PTR_W = $clog2(OUT_DEPTH);
  localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);

  // Input commands
  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD   = 3'd0,
    CMD_ACCEPT = 3'd1,
    CMD_SYMBOL = 3'd2,
    CMD_END    = 3'd3,
    CMD_CLEAR  = 3'd4
  } cmd_e_t;

  // Transition table entry: defined bit plus destination state
  typedef struct packed {
    logic               valid;
    logic [STATE_W-1:0] state;
  } tbl_entry_t;

  // Write request towards the transition memory
  typedef struct packed {
    logic                  en;
    logic [TBL_ADDR_W-1:0] addr;
    tbl_entry_t            data;
  } tbl_wr_t;

  // One result beat
  typedef struct packed {
    logic [STATE_W-1:0] current_state;
    logic               dead;
    logic               is_final;
    logic               accepted;
  } result_t;

  // Table address of (state, symbol); only meaningful for in-range values
  function automatic logic [TBL_ADDR_W-1:0] tbl_addr(input logic [STATE_W-1:0] st,
                                                      input logic [SYM_W-1:0]   sym);
    logic [TBL_ADDR_W-1:0] row;
    logic [TBL_ADDR_W-1:0] col;
    row = TBL_ADDR_W'(st) << SYMBOL_BITS;
    col = TBL_ADDR_W'(sym[SYMBOL_BITS-1:0]);
    return row | col;
  endfunction

  function automatic logic state_in_range(input logic [STATE_W-1:0] st);
    return 32'(st) < NUM_STATES;
  endfunction

  function automatic logic sym_in_range(input logic [SYM_W-1:0] sym);
    return 32'(sym) < NUM_SYMBOLS;
  endfunction

endpackage

[rtl/tdfa_trans_mem.sv]
`timescale 1ns / 1ps
// Transition table: synchronous memory, one write and one registered read per cycle.
// Holds the clearing sweep run after reset and on a clear request. Uses tdfa_pkg.
module tdfa_trans_mem import tdfa_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  clr_start,
  input  tbl_wr_t               wr,
  input  logic                  rd_en,
  input  logic [TBL_ADDR_W-1:0] rd_addr,
  output tbl_entry_t            rd_data,
  output logic                  clr_busy,
  output logic [TBL_ADDR_W-1:0] clr_addr
);

  tbl_entry_t            mem [TBL_DEPTH];
  tbl_entry_t            rd_data_r;
  logic                  busy_r;
  logic                  busy_nxt;
  logic [TBL_ADDR_W-1:0] sweep_r;
  logic [TBL_ADDR_W-1:0] sweep_nxt;
  logic                  sweep_last;

  assign sweep_last = (sweep_r == TBL_ADDR_W'(TBL_DEPTH - 1));

  // Sweep control: one entry cleared per cycle
  always_comb begin
    busy_nxt  = busy_r;
    sweep_nxt = sweep_r;
    if (busy_r) begin
      sweep_nxt = sweep_r + 1'b1;
      if (sweep_last) begin
        busy_nxt = 1'b0;
      end
    end
    if (clr_start) begin
      busy_nxt  = 1'b1;
      sweep_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b1;
      sweep_r <= '0;
    end else begin
      busy_r  <= busy_nxt;
      sweep_r <= sweep_nxt;
    end
  end

  // Memory array: sweep owns the write port while busy
  always_ff @(posedge clk) begin
    if (busy_r) begin
      mem[sweep_r] <= '0;
    end else if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data  = rd_data_r;
  assign clr_busy = busy_r;
  assign clr_addr = sweep_r;

endmodule

[rtl/tdfa_out_fifo.sv]
`timescale 1ns / 1ps
// Three-entry result queue between the step logic and the result port.
// Uses tdfa_pkg for the result beat type and sizes.
module tdfa_out_fifo import tdfa_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  result_t              push_data,
  input  logic                 pop,
  output result_t              head,
  output logic                 not_empty,
  output logic [OUT_CNT_W-1:0] count
);

  result_t              entry_r [OUT_DEPTH];
  logic [OUT_PTR_W-1:0] wr_ptr_r;
  logic [OUT_PTR_W-1:0] rd_ptr_r;
  logic [OUT_CNT_W-1:0] cnt_r;

  function automatic logic [OUT_PTR_W-1:0] ptr_inc(input logic [OUT_PTR_W-1:0] p);
    return (p == OUT_PTR_W'(OUT_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= ptr_inc(wr_ptr_r);
      end
      if (pop) begin
        rd_ptr_r <= ptr_inc(rd_ptr_r);
      end
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  // Payload storage
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

  assign head      = entry_r[rd_ptr_r];
  assign not_empty = (cnt_r != '0);
  assign count     = cnt_r;

  // Never push into a full queue unless a beat leaves in the same cycle
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    (push && cnt_r == OUT_CNT_W'(OUT_DEPTH)) |-> pop)
    else $error("result queue overflow");

  // Never pop an empty queue
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> (cnt_r != '0))
    else $error("result queue underflow");

endmodule

[rtl/table_driven_dfa_matcher_top.sv]
`timescale 1ns / 1ps
// Top level of the table driven DFA matcher: command decode, step stage, accept flags.
// Instantiates tdfa_trans_mem and tdfa_out_fifo; uses tdfa_pkg.
//
// Usage
//   Input channel (in_valid / in_stall) carries command beats: load a transition,
//   set an accept flag, step one symbol, end a string, or clear both tables.
//   Result channel (out_valid / out_stall) gives one beat for every symbol or end
//   beat and none for the others. cfg_we / cfg_wdata write the start state; write
//   it only while the block is idle.
//   Path: a result passes through the step stage register and then the result
//   queue before it is offered, and is taken at an edge where out_stall is low.
//   Throughput: one beat per cycle while in_stall is low. The next-state lookup
//   reads the transition memory at an address built from the previous read's data,
//   so a symbol can follow a symbol on the very next cycle.
//   Reset: both tables are cleared; the transition memory is swept one entry per
//   cycle over all 16384 entries, with in_stall high; the accept flags are cleared
//   while it covers the first 64 entries. A clear command runs the same sweep.
//   The string in progress keeps its state across a clear.
//   Receiver stall: results collect in a three-entry queue; in_stall rises when
//   the queue and the step stage together could not take one more result.
module table_driven_dfa_matcher_top import tdfa_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  // configuration
  input  logic               cfg_we,
  input  logic [STATE_W-1:0] cfg_wdata,
  // input channel
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [CMD_W-1:0]   in_command,
  input  logic [STATE_W-1:0] in_from_state,
  input  logic [SYM_W-1:0]   in_symbol,
  input  logic [STATE_W-1:0] in_to_state,
  input  logic               in_flag,
  // result channel
  output logic               out_valid,
  input  logic               out_stall,
  output logic [STATE_W-1:0] out_current_state,
  output logic               out_dead,
  output logic               out_is_final,
  output logic               out_accepted
);

  // Architectural string state and start register
  logic [STATE_W-1:0]    start_r;
  logic [STATE_W-1:0]    present_r;
  logic                  dead_r;
  logic                  fresh_r;
  logic [NUM_STATES-1:0] acc_r;

  // Step stage (holds a beat in the cycle after its acceptance)
  logic                  b_sym_r;
  logic                  b_end_r;
  logic [STATE_W-1:0]    b_cur_r;
  logic                  b_dead_r;
  logic                  b_ok_r;
  logic                  b_acc_r;

  logic                  accept;
  logic                  is_load;
  logic                  is_acc;
  logic                  is_sym;
  logic                  is_end;
  logic                  is_clr;
  logic                  clr_busy;
  logic [TBL_ADDR_W-1:0] clr_addr;
  tbl_wr_t               tbl_wr;
  tbl_entry_t            rd_data;
  logic                  b_hit;
  logic [STATE_W-1:0]    b_next_state;
  logic                  b_next_dead;
  logic                  b_res;
  result_t               b_result;
  logic                  view_fresh;
  logic [STATE_W-1:0]    view_state;
  logic                  view_dead;
  logic [STATE_W-1:0]    cur_view;
  logic                  pop;
  result_t               head;
  logic                  fifo_nempty;
  logic [OUT_CNT_W-1:0]  fifo_cnt;
  logic [STATE_IDX_W-1:0] acc_idx;
  logic [STATE_IDX_W-1:0] cur_idx;
  logic                  acc_wipe;
  logic [STATE_IDX_W-1:0] wipe_idx;

  // Command decode
  always_comb begin
    is_load = 1'b0;
    is_acc  = 1'b0;
    is_sym  = 1'b0;
    is_end  = 1'b0;
    is_clr  = 1'b0;
    unique case (in_command)
      CMD_LOAD:   is_load = 1'b1;
      CMD_ACCEPT: is_acc  = 1'b1;
      CMD_SYMBOL: is_sym  = 1'b1;
      CMD_END:    is_end  = 1'b1;
      CMD_CLEAR:  is_clr  = 1'b1;
      default:    ;
    endcase
  end

  // Flow control: room for the step stage's result plus one more
  assign b_res    = b_sym_r | b_end_r;
  assign in_stall = clr_busy ||
                    ((32'(fifo_cnt) + 32'(b_res)) >= OUT_DEPTH);
  assign accept   = in_valid && !in_stall;

  // Outcome of the symbol in the step stage
  assign b_hit        = !b_dead_r && b_ok_r && rd_data.valid;
  assign b_next_state = b_hit ? rd_data.state : b_cur_r;
  assign b_next_dead  = !b_hit;

  // State as seen by the next beat, including the one in the step stage
  always_comb begin
    view_fresh = fresh_r;
    view_state = present_r;
    view_dead  = dead_r;
    if (b_sym_r) begin
      view_fresh = 1'b0;
      view_state = b_next_state;
      view_dead  = b_next_dead;
    end else if (b_end_r) begin
      view_fresh = 1'b1;
      view_dead  = 1'b0;
    end
  end
  assign cur_view = view_fresh ? start_r : view_state;
  assign cur_idx  = STATE_IDX_W'(cur_view);
  assign acc_idx  = STATE_IDX_W'(in_from_state);

  // Accept flag clearing rides on the first entries of the table sweep
  assign acc_wipe = clr_busy && (clr_addr < TBL_ADDR_W'(NUM_STATES));
  assign wipe_idx = STATE_IDX_W'(clr_addr);

  // Transition load towards memory
  always_comb begin
    tbl_wr.en         = accept && is_load && state_in_range(in_from_state) &&
                        state_in_range(in_to_state) && sym_in_range(in_symbol);
    tbl_wr.addr       = tbl_addr(in_from_state, in_symbol);
    tbl_wr.data.valid = in_flag;
    tbl_wr.data.state = in_to_state;
  end

  tdfa_trans_mem u_mem (
    .clk       (clk),
    .rst_n     (rst_n),
    .clr_start (accept && is_clr),
    .wr        (tbl_wr),
    .rd_en     (accept && is_sym),
    .rd_addr   (tbl_addr(cur_view, in_symbol)),
    .rd_data   (rd_data),
    .clr_busy  (clr_busy),
    .clr_addr  (clr_addr)
  );

  // Control registers: start state, string state, step stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r   <= '0;
      present_r <= '0;
      dead_r    <= 1'b0;
      fresh_r   <= 1'b1;
      b_sym_r   <= 1'b0;
      b_end_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        start_r <= cfg_wdata;
      end
      // commit the step stage
      if (b_sym_r) begin
        present_r <= b_next_state;
        dead_r    <= b_next_dead;
        fresh_r   <= 1'b0;
      end else if (b_end_r) begin
        present_r <= start_r;
        dead_r    <= 1'b0;
        fresh_r   <= 1'b1;
      end
      b_sym_r <= accept && is_sym;
      b_end_r <= accept && is_end;
    end
  end

  // Accept flag table: one entry cleared per sweep cycle, else one set per beat
  always_ff @(posedge clk) begin
    if (acc_wipe) begin
      acc_r[wipe_idx] <= 1'b0;
    end else if (accept && is_acc && state_in_range(in_from_state)) begin
      acc_r[acc_idx] <= in_flag;
    end
  end

  // Step stage payload
  always_ff @(posedge clk) begin
    if (accept) begin
      b_cur_r  <= cur_view;
      b_dead_r <= view_dead;
      b_ok_r   <= state_in_range(cur_view) && sym_in_range(in_symbol);
      b_acc_r  <= state_in_range(cur_view) && acc_r[cur_idx];
    end
  end

  // Result beat of the step stage
  always_comb begin
    if (b_end_r) begin
      b_result.current_state = b_cur_r;
      b_result.dead          = b_dead_r;
      b_result.is_final      = 1'b1;
      b_result.accepted      = !b_dead_r && b_acc_r;
    end else begin
      b_result.current_state = b_next_state;
      b_result.dead          = b_next_dead;
      b_result.is_final      = 1'b0;
      b_result.accepted      = 1'b0;
    end
  end

  assign pop = fifo_nempty && !out_stall;

  tdfa_out_fifo u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (b_res),
    .push_data (b_result),
    .pop       (pop),
    .head      (head),
    .not_empty (fifo_nempty),
    .count     (fifo_cnt)
  );

  assign out_valid         = fifo_nempty;
  assign out_current_state = head.current_state;
  assign out_dead          = head.dead;
  assign out_is_final      = head.is_final;
  assign out_accepted      = head.accepted;

  // A dead string stays dead and keeps its state on further symbols
  a_dead_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (b_sym_r && b_dead_r) |-> (b_next_dead && b_next_state == b_cur_r))
    else $error("dead string moved");

  // An end beat restarts the string
  a_end_restart: assert property (@(posedge clk) disable iff (!rst_n)
    b_end_r |=> (fresh_r && !dead_r))
    else $error("string not restarted after end");

  // No beat is taken while the transition memory is being swept
  a_no_accept_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    (clr_busy && !b_res) |=> !(b_sym_r || b_end_r) || !$past(clr_busy))
    else $error("beat taken during sweep");

  // Verdict only on end results
  a_verdict_final: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_is_final) |-> !out_accepted)
    else $error("verdict on a non-final result");

endmodule

[tb/tdfa_checker.sv]
`timescale 1ns / 1ps
// Checker for the table driven DFA matcher: watches the config port and both channels,
// tracks the automaton, and compares every result beat. Depends on tdfa_pkg.
module tdfa_checker import tdfa_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [STATE_W-1:0] cfg_wdata,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [CMD_W-1:0]   in_command,
  input  logic [STATE_W-1:0] in_from_state,
  input  logic [SYM_W-1:0]   in_symbol,
  input  logic [STATE_W-1:0] in_to_state,
  input  logic               in_flag,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic [STATE_W-1:0] out_current_state,
  input  logic               out_dead,
  input  logic               out_is_final,
  input  logic               out_accepted,
  output int unsigned        mismatches,
  output int unsigned        outstanding,
  output int unsigned        results_checked
);

  // Shadow copy of the automaton
  tbl_entry_t         next_state_tbl [NUM_STATES][NUM_SYMBOLS];
  logic               accepting [NUM_STATES];
  logic [STATE_W-1:0] start_st;
  logic [STATE_W-1:0] walk_st;
  logic               dead_st;
  logic               fresh_st;

  result_t     due_results [$];
  int unsigned err_cnt;
  int unsigned chk_cnt;

  task automatic wipe_tables();
    for (int s = 0; s < NUM_STATES; s++) begin
      accepting[s] = 1'b0;
      for (int y = 0; y < NUM_SYMBOLS; y++) next_state_tbl[s][y] = '0;
    end
  endtask

  // Advance the shadow automaton by one accepted input beat
  task automatic step_automaton(input logic [CMD_W-1:0]   cmd,
                                input logic [STATE_W-1:0] src_st,
                                input logic [SYM_W-1:0]   sym,
                                input logic [STATE_W-1:0] dst_st,
                                input logic               flg);
    logic [STATE_W-1:0] cur;
    result_t            res;
    cur = fresh_st ? start_st : walk_st;
    case (cmd_e_t'(cmd))
      CMD_LOAD: begin
        next_state_tbl[src_st][sym].valid = flg;
        next_state_tbl[src_st][sym].state = flg ? dst_st : '0;
      end
      CMD_ACCEPT: accepting[src_st] = flg;
      CMD_SYMBOL: begin
        // once dead the state is frozen until the end beat
        if (!dead_st) begin
          if (next_state_tbl[cur][sym].valid) cur = next_state_tbl[cur][sym].state;
          else dead_st = 1'b1;
        end
        walk_st  = cur;
        fresh_st = 1'b0;
        res.current_state = cur;
        res.dead          = dead_st;
        res.is_final      = 1'b0;
        res.accepted      = 1'b0;
        due_results = {due_results, res};
      end
      CMD_END: begin
        res.current_state = cur;
        res.dead          = dead_st;
        res.is_final      = 1'b1;
        res.accepted      = !dead_st && accepting[cur];
        due_results = {due_results, res};
        walk_st  = start_st;
        dead_st  = 1'b0;
        fresh_st = 1'b1;
      end
      CMD_CLEAR: wipe_tables();
      default: ;  // unused codes are dropped
    endcase
  endtask

  task automatic compare_field(input string name, input int unsigned want,
                               input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
      err_cnt++;
    end
  endtask

  always @(posedge clk) begin : track
    result_t got;
    result_t want;
    if (!rst_n) begin
      wipe_tables();
      start_st = '0;
      walk_st  = '0;
      dead_st  = 1'b0;
      fresh_st = 1'b1;
      due_results.delete();
      err_cnt = 0;
      chk_cnt = 0;
    end else begin
      if (cfg_we) start_st = cfg_wdata;
      // result side first, so a beat accepted this edge cannot match itself
      if (out_valid && !out_stall) begin
        got = {out_current_state, out_dead, out_is_final, out_accepted};
        if (due_results.size() == 0) begin
          $display("%0t: unexpected result beat, expected none, actual state %0d dead %0b final %0b accepted %0b",
                   $time, got.current_state, got.dead, got.is_final, got.accepted);
          err_cnt++;
        end else begin
          want = due_results.pop_front();
          compare_field("current_state", want.current_state, got.current_state);
          compare_field("dead", want.dead, got.dead);
          compare_field("is_final", want.is_final, got.is_final);
          compare_field("accepted", want.accepted, got.accepted);
          chk_cnt++;
        end
      end
      if (in_valid && !in_stall)
        step_automaton(in_command, in_from_state, in_symbol, in_to_state, in_flag);
    end
    mismatches      <= err_cnt;
    outstanding     <= due_results.size();
    results_checked <= chk_cnt;
  end

endmodule

[tb/tb_table_driven_dfa_matcher_top.sv]
`timescale 1ns / 1ps
// Testbench top for table_driven_dfa_matcher_top: directed beats, then phases that
// program a small automaton and run strings through it. Uses tdfa_pkg and tdfa_checker.
module tb_table_driven_dfa_matcher_top;
  import tdfa_pkg::*;

  localparam int unsigned ITEM_TARGET   = 1350;
  localparam int unsigned NUM_PHASES    = 6;
  localparam int unsigned SET_SIZE      = 8;
  localparam int unsigned ALPHA_SIZE    = 4;
  localparam int unsigned CYCLE_LIMIT   = 1000000;
  localparam int unsigned SETTLE_CYCLES = 8;
  // codes above the clear command are unused by the block
  localparam logic [CMD_W-1:0] CMD_SPARE_LO = CMD_W'(CMD_CLEAR + 1);
  localparam logic [CMD_W-1:0] CMD_SPARE_HI = '1;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_we = 1'b0;
  logic [STATE_W-1:0] cfg_wdata = '0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [CMD_W-1:0]   in_command = '0;
  logic [STATE_W-1:0] in_from_state = '0;
  logic [SYM_W-1:0]   in_symbol = '0;
  logic [STATE_W-1:0] in_to_state = '0;
  logic               in_flag = 1'b0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [STATE_W-1:0] out_current_state;
  logic               out_dead;
  logic               out_is_final;
  logic               out_accepted;

  int unsigned mismatches;
  int unsigned outstanding;
  int unsigned results_checked;

  int unsigned        items_sent = 0;
  int unsigned        clears_sent = 0;
  int unsigned        start_writes = 0;
  int unsigned        cycle_cnt = 0;
  int unsigned        stall_hold = 0;
  logic               quiet_tail = 1'b0;
  logic [STATE_W-1:0] live_set [SET_SIZE];
  logic [SYM_W-1:0]   alpha [ALPHA_SIZE];

  table_driven_dfa_matcher_top dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_command        (in_command),
    .in_from_state     (in_from_state),
    .in_symbol         (in_symbol),
    .in_to_state       (in_to_state),
    .in_flag           (in_flag),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_current_state (out_current_state),
    .out_dead          (out_dead),
    .out_is_final      (out_is_final),
    .out_accepted      (out_accepted)
  );

  tdfa_checker u_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_command        (in_command),
    .in_from_state     (in_from_state),
    .in_symbol         (in_symbol),
    .in_to_state       (in_to_state),
    .in_flag           (in_flag),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_current_state (out_current_state),
    .out_dead          (out_dead),
    .out_is_final      (out_is_final),
    .out_accepted      (out_accepted),
    .mismatches        (mismatches),
    .outstanding       (outstanding),
    .results_checked   (results_checked)
  );

  // 100 MHz clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("table_driven_dfa_matcher_top verification failed");
      $finish;
    end
  end

  // Receiver back-pressure: random stall bursts between open stretches
  always @(posedge clk) begin
    if (stall_hold != 0) begin
      stall_hold <= stall_hold - 1;
    end else if (quiet_tail) begin
      out_stall <= 1'b0;
    end else if ($urandom_range(0, 2) == 0) begin
      out_stall  <= 1'b1;
      stall_hold <= $urandom_range(0, 11);
    end else begin
      out_stall  <= 1'b0;
      stall_hold <= $urandom_range(0, 39);
    end
  end

  // Offer one beat, with an occasional idle burst first, and hold it until taken
  task automatic send_beat(input logic [CMD_W-1:0]   cmd,
                           input logic [STATE_W-1:0] src_st,
                           input logic [SYM_W-1:0]   sym,
                           input logic [STATE_W-1:0] dst_st,
                           input logic               flg);
    if (!quiet_tail && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_command    <= cmd;
    in_from_state <= src_st;
    in_symbol     <= sym;
    in_to_state   <= dst_st;
    in_flag       <= flg;
    do @(posedge clk); while (in_stall);
    if (cmd <= CMD_CLEAR) items_sent++;
    if (cmd == CMD_CLEAR) clears_sent++;
  endtask

  // Wait for the block to go idle, then write the start state
  task automatic set_start_state(input logic [STATE_W-1:0] value);
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    while (in_stall) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    start_writes++;
  endtask

  function automatic logic [SYM_W-1:0] pick_symbol();
    if ($urandom_range(0, 9) != 0) return alpha[$urandom_range(0, ALPHA_SIZE - 1)];
    return SYM_W'($urandom);
  endfunction

  function automatic logic [STATE_W-1:0] any_state();
    return STATE_W'($urandom_range(0, NUM_STATES - 1));
  endfunction

  // One string: symbols mostly from the phase alphabet, then the end beat
  task automatic run_string(input int unsigned len);
    for (int unsigned i = 0; i < len; i++)
      send_beat(CMD_SYMBOL, any_state(), pick_symbol(), any_state(), 1'($urandom));
    send_beat(CMD_END, any_state(), SYM_W'($urandom), any_state(), 1'($urandom));
  endtask

  // Random beat with random fields; clears are kept out of the noise
  task automatic send_noise();
    logic [CMD_W-1:0] cmd;
    cmd = CMD_W'($urandom_range(0, CMD_SPARE_HI));
    if (cmd == CMD_CLEAR) cmd = CMD_LOAD;
    send_beat(cmd, any_state(), SYM_W'($urandom), any_state(), 1'($urandom));
  endtask

  initial begin : stimulus
    int unsigned directed_items;
    logic [STATE_W-1:0] start_val;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed beats, start state at its reset value
    send_beat(CMD_END, '0, '0, '0, 1'b0);          // empty string, nothing accepting
    send_beat(CMD_ACCEPT, '0, '0, '0, 1'b1);
    send_beat(CMD_END, '0, '0, '0, 1'b0);          // empty string accepted
    send_beat(CMD_SYMBOL, '0, '1, '0, 1'b0);       // no entry: string dies
    send_beat(CMD_SYMBOL, '1, '0, '1, 1'b1);       // dead: state held, beat still returned
    send_beat(CMD_END, '0, '0, '0, 1'b0);
    send_beat(CMD_LOAD, '0, '1, '1, 1'b1);         // 0 --ff--> 63
    send_beat(CMD_LOAD, '1, '0, '0, 1'b1);         // 63 --00--> 0
    send_beat(CMD_ACCEPT, '1, '1, '1, 1'b1);
    send_beat(CMD_SYMBOL, '0, '1, '0, 1'b0);
    send_beat(CMD_END, '0, '0, '0, 1'b0);
    send_beat(CMD_SYMBOL, '0, '1, '0, 1'b0);
    send_beat(CMD_SYMBOL, '0, '0, '0, 1'b0);
    send_beat(CMD_END, '1, '1, '1, 1'b1);
    send_beat(CMD_LOAD, '0, '1, '1, 1'b0);         // undefine the entry again
    send_beat(CMD_SYMBOL, '0, '1, '0, 1'b0);
    send_beat(CMD_END, '0, '0, '0, 1'b0);
    send_beat(CMD_SPARE_LO, '1, '1, '1, 1'b1);     // unused codes: ignored
    send_beat(CMD_SPARE_HI, '1, '1, '1, 1'b1);
    send_beat(CMD_ACCEPT, '0, '0, '0, 1'b0);
    send_beat(CMD_LOAD, '0, 8'hAA, 6'h2A, 1'b1);
    send_beat(CMD_SYMBOL, '0, 8'hAA, '0, 1'b0);
    send_beat(CMD_CLEAR, '1, '1, '1, 1'b1);        // string keeps its state across this
    send_beat(CMD_SYMBOL, '0, 8'hAA, '0, 1'b0);
    send_beat(CMD_END, '0, '0, '0, 1'b0);
    send_beat(CMD_SYMBOL, '0, 8'hAA, '0, 1'b0);    // entry gone after the clear
    send_beat(CMD_END, '0, '0, '0, 1'b0);
    directed_items = items_sent;

    // Random phases: program a small automaton, then run strings and noise
    for (int unsigned p = 0; p < NUM_PHASES; p++) begin
      quiet_tail <= (p == NUM_PHASES - 1);
      if (p == 0) start_val = '1;
      else if (p == 1) start_val = '0;
      else start_val = any_state();
      set_start_state(start_val);
      if (p % 3 == 1) send_beat(CMD_CLEAR, any_state(), SYM_W'($urandom), any_state(), 1'b0);

      live_set[0] = start_val;
      for (int unsigned s = 1; s < SET_SIZE; s++) live_set[s] = any_state();
      for (int unsigned a = 0; a < ALPHA_SIZE; a++) alpha[a] = SYM_W'($urandom);
      if (p == 0) alpha[0] = '0;
      if (p == 1) alpha[0] = '1;

      for (int unsigned s = 0; s < SET_SIZE; s++)
        for (int unsigned a = 0; a < ALPHA_SIZE; a++)
          send_beat(CMD_LOAD, live_set[s], alpha[a], live_set[$urandom_range(0, SET_SIZE - 1)],
                    $urandom_range(0, 6) != 0);
      for (int unsigned s = 0; s < SET_SIZE; s++)
        send_beat(CMD_ACCEPT, live_set[s], SYM_W'($urandom), any_state(), 1'($urandom));

      while (items_sent < directed_items + (p + 1) * (ITEM_TARGET / NUM_PHASES)) begin
        if ($urandom_range(0, 4) != 0) run_string($urandom_range(0, 10));
        else send_noise();
      end
    end

    // Drain and settle
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Ran %0d beats (%0d directed) over %0d phases, %0d table clears, %0d start writes",
             items_sent, directed_items, NUM_PHASES, clears_sent, start_writes);
    $display("Checked %0d result beats, %0d mismatches", results_checked, mismatches);
    if (mismatches == 0 && outstanding == 0)
      $display("table_driven_dfa_matcher_top verification clean");
    else
      $display("table_driven_dfa_matcher_top verification failed");
    $finish;
  end

endmodule

[table_driven_dfa_matcher_top.f]
rtl/tdfa_pkg.sv
rtl/tdfa_trans_mem.sv
rtl/tdfa_out_fifo.sv
rtl/table_driven_dfa_matcher_top.sv
tb/tdfa_checker.sv
tb/tb_table_driven_dfa_matcher_top.sv
